@@ rtl/connection_tuple_lookup_table_unit_defines.svh @@
// ---------------------------------------------------------------------------
// connection tuple lookup table assertion macros
// shared assertion helpers for the lookup table rtl
// ---------------------------------------------------------------------------
`ifndef CONNECTION_TUPLE_LOOKUP_TABLE_UNIT_DEFINES_SVH
`define CONNECTION_TUPLE_LOOKUP_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CTLT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CTLT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CTLT_ASSERT_IMP(lbl, ante, cons)
`define CTLT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/ctlt_pkg.sv @@
// ---------------------------------------------------------------------------
// connection tuple lookup table package
// constants, types and hash helpers shared by the lookup table rtl
// ---------------------------------------------------------------------------
package ctlt_pkg;
   localparam int ENTRIES     = 64;
   localparam int ENT_W       = $clog2(ENTRIES);
   localparam int BUCKETS     = 521;
   localparam int BKT_W       = 10;
   localparam int NUM_CLASS   = 5;
   localparam int HASH_W      = 32;
   localparam int FOLD_MUL    = (2**16) % BUCKETS;
   localparam int FOLD_STEPS  = 3;
   localparam int FOLD_W      = 17;
   localparam int RECIP_SHIFT = FOLD_W + BKT_W;
   localparam int RECIP_MUL   = (2**RECIP_SHIFT + BUCKETS - 1) / BUCKETS;
   localparam int PROD_W      = FOLD_W + RECIP_SHIFT - BKT_W + 1;
   localparam int Q_W         = PROD_W - RECIP_SHIFT;
   localparam int HASH_STEPS  = FOLD_STEPS + 2;
   localparam int CNT_W       = $clog2(HASH_STEPS);

   localparam logic [1:0] OP_INS    = 2'd0;
   localparam logic [1:0] OP_REM    = 2'd1;
   localparam logic [1:0] OP_LOOK   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] CL_EXACT = 3'd0;
   localparam logic [2:0] CL_PA    = 3'd1;
   localparam logic [2:0] CL_PORT  = 3'd2;
   localparam logic [2:0] CL_ADDR  = 3'd3;
   localparam logic [2:0] CL_ANY   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_HASH, ST_APPLY, ST_SCAN, ST_RESP
   } st_type;

   typedef struct packed {
      logic [63:0] rh;
      logic [63:0] rl;
      logic [15:0] rp;
      logic [63:0] lh;
      logic [63:0] ll;
      logic [15:0] lp;
   } key_type;

   typedef logic [NUM_CLASS-1:0][BKT_W-1:0] bkt_vec_type;

   typedef struct packed {
      logic             en;
      logic             ins;
      logic [ENT_W-1:0] id;
      logic             old_valid;
      logic [ENT_W-1:0] old_age;
      logic [2:0]       cls;
      logic [BKT_W-1:0] bucket;
   } upd_type;

   typedef struct packed {
      logic             tok;
      logic             hit;
      logic [2:0]       cls;
      logic [ENT_W-1:0] age;
      logic [ENT_W-1:0] id;
   } best_type;

   function automatic logic [HASH_W-1:0] hash_key(logic [7:0] ra, logic [15:0] rp,
                                                  logic [7:0] la, logic [15:0] lp);
      return {ra, 24'b0} ^ {rp, 16'b0} ^ {16'b0, la, 8'b0} ^ {16'b0, lp};
   endfunction

   // upper half folded back in, since 2**16 is congruent to FOLD_MUL
   function automatic logic [HASH_W-1:0] fold_hash(logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] hi;
      logic [HASH_W-1:0] lo;
      hi = {16'b0, v[HASH_W-1:16]};
      lo = {16'b0, v[15:0]};
      return hi * HASH_W'(FOLD_MUL) + lo;
   endfunction

   function automatic logic [Q_W-1:0] recip_quot(logic [FOLD_W-1:0] v);
      logic [PROD_W-1:0] p;
      p = PROD_W'(v) * PROD_W'(RECIP_MUL);
      return p[PROD_W-1:RECIP_SHIFT];
   endfunction

   function automatic logic [BKT_W-1:0] recip_rem(logic [FOLD_W-1:0] v,
                                                  logic [Q_W-1:0] q);
      logic [FOLD_W-1:0] qd;
      logic [FOLD_W-1:0] r;
      qd = FOLD_W'(q) * FOLD_W'(BUCKETS);
      r  = v - qd;
      return r[BKT_W-1:0];
   endfunction

   function automatic logic [2:0] class_of(key_type k);
      logic rnone;
      logic lnone;
      rnone = (k.rh == 64'd0) && (k.rl == 64'd0);
      lnone = (k.lh == 64'd0) && (k.ll == 64'd0);
      if (!rnone) return CL_EXACT;
      else if (!lnone) return (k.lp == 16'd0) ? CL_ADDR : CL_PA;
      else return (k.lp == 16'd0) ? CL_ANY : CL_PORT;
   endfunction
endpackage

@@ rtl/ctlt_hash.sv @@
// ---------------------------------------------------------------------------
// bucket hash unit
// five key hashes reduced modulo the bucket count: three folds of the upper
// half, then a reciprocal multiply and a subtract, one step per cycle
// ---------------------------------------------------------------------------
module ctlt_hash (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ctlt_pkg::key_type key,
   output logic              done,
   output ctlt_pkg::bkt_vec_type bkt
);
   import ctlt_pkg::*;

   logic [NUM_CLASS-1:0][HASH_W-1:0] x_ff, x_in;
   logic [NUM_CLASS-1:0][Q_W-1:0]    q_ff, q_in;
   bkt_vec_type                      rem_ff, rem_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   always_comb begin
      x_in    = x_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in[0] = hash_key(key.rl[7:0], key.rp, key.ll[7:0], key.lp);
         x_in[1] = hash_key(8'd0, 16'd0, key.ll[7:0], key.lp);
         x_in[2] = hash_key(8'd0, 16'd0, 8'd0, key.lp);
         x_in[3] = hash_key(8'd0, 16'd0, key.ll[7:0], 16'd0);
         x_in[4] = hash_key(8'd0, 16'd0, 8'd0, 16'd0);
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int l = 0; l < NUM_CLASS; l++) begin
            if (cnt_ff < CNT_W'(FOLD_STEPS)) begin
               x_in[l] = fold_hash(x_ff[l]);
            end else if (cnt_ff == CNT_W'(FOLD_STEPS)) begin
               q_in[l] = recip_quot(x_ff[l][FOLD_W-1:0]);
            end else begin
               rem_in[l] = recip_rem(x_ff[l][FOLD_W-1:0], q_ff[l]);
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(HASH_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign bkt  = rem_ff;
endmodule

@@ rtl/ctlt_cell.sv @@
// ---------------------------------------------------------------------------
// slot cell
// one table slot with its match logic and one stage of the scan chain
// ---------------------------------------------------------------------------
module ctlt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ctlt_pkg::ENT_W-1:0] cell_id,
   input  ctlt_pkg::upd_type         upd,
   input  ctlt_pkg::key_type         key,
   input  ctlt_pkg::bkt_vec_type     bkt,
   input  ctlt_pkg::best_type        best_prev,
   output ctlt_pkg::best_type        best_next,
   output logic                      valid,
   output logic [ctlt_pkg::ENT_W-1:0] age,
   output logic [2:0]                cls
);
   import ctlt_pkg::*;

   logic             valid_ff, valid_in;
   logic [ENT_W-1:0] age_ff, age_in;
   logic [2:0]       cls_ff;
   logic [BKT_W-1:0] bucket_ff;
   key_type          key_ff;
   best_type         best_ff, best_in;
   logic             here;
   logic             dec;
   logic             own;
   logic             better;

   assign here = (upd.id == cell_id);
   assign dec  = upd.old_valid && (age_ff > upd.old_age);

   always_comb begin
      valid_in = valid_ff;
      age_in   = age_ff;
      if (upd.en) begin
         if (upd.ins && here) begin
            valid_in = 1'b1;
            age_in   = '0;
         end else if (here) begin
            valid_in = 1'b0;
         end else if (valid_ff) begin
            age_in = age_ff - {{(ENT_W-1){1'b0}}, dec} + {{(ENT_W-1){1'b0}}, upd.ins};
         end
      end
   end

   always_comb begin
      case (cls_ff)
         CL_EXACT: own = (bucket_ff == bkt[0]) && (key_ff == key);
         CL_PA:    own = (bucket_ff == bkt[1]) && (key_ff.lp == key.lp) &&
                         (key_ff.lh == key.lh) && (key_ff.ll == key.ll);
         CL_PORT:  own = (bucket_ff == bkt[2]) && (key_ff.lp == key.lp);
         CL_ADDR:  own = (bucket_ff == bkt[3]) && (key_ff.lh == key.lh) &&
                         (key_ff.ll == key.ll);
         CL_ANY:   own = (bucket_ff == bkt[4]);
         default:  own = 1'b0;
      endcase
   end

   assign better = !best_prev.hit || (cls_ff < best_prev.cls) ||
                   ((cls_ff == best_prev.cls) && (age_ff < best_prev.age));

   always_comb begin
      best_in = best_prev;
      if (best_prev.tok && valid_ff && own && better) begin
         best_in.hit = 1'b1;
         best_in.cls = cls_ff;
         best_in.age = age_ff;
         best_in.id  = cell_id;
      end
   end

   always_ff @(posedge clock) begin
      age_ff <= age_in;
      if (upd.en && upd.ins && here) begin
         cls_ff    <= upd.cls;
         bucket_ff <= upd.bucket;
         key_ff    <= key;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         best_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         best_ff  <= best_in;
      end
   end

   assign best_next = best_ff;
   assign valid     = valid_ff;
   assign age       = age_ff;
   assign cls       = cls_ff;
endmodule

@@ rtl/connection_tuple_lookup_table_unit.sv @@
// ---------------------------------------------------------------------------
// connection tuple lookup table unit
// 64-slot connection table with five-class wildcard lookup
// ---------------------------------------------------------------------------
// One item at a time. Every item first passes through the bucket hash
// unit, which folds five 32-bit keys three times and then reduces them
// modulo 521 with a reciprocal multiply and a subtract. Insert and remove
// then update all slots together in the apply state. A lookup sends a
// scan wave through the row of 64 slot cells, one cell per cycle. A
// result waits in the result register, and holds the input side off, until
// the output register is empty or rsp_ready takes what it holds.
`include "connection_tuple_lookup_table_unit_defines.svh"
module connection_tuple_lookup_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_entry_id,
   input  logic [63:0] req_remote_addr_hi,
   input  logic [63:0] req_remote_addr_lo,
   input  logic [15:0] req_remote_port,
   input  logic [63:0] req_local_addr_hi,
   input  logic [63:0] req_local_addr_lo,
   input  logic [15:0] req_local_port,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [5:0]  rsp_hit_entry,
   output logic [2:0]  rsp_hit_class
);
   import ctlt_pkg::*;

   st_type           state_ff, state_in;
   logic [1:0]       op_ff;
   logic [5:0]       id_ff;
   key_type          key_ff, key_req;
   logic             accept;
   logic             hash_done;
   bkt_vec_type      bkt;
   best_type         chain [ENTRIES+1];
   logic [ENTRIES-1:0] cell_valid;
   logic [ENT_W-1:0] cell_age [ENTRIES];
   logic [2:0]       cell_cls [ENTRIES];
   logic [ENT_W-1:0] id_idx;
   logic             in_range;
   logic             old_valid;
   upd_type          upd;
   logic             chain_start;
   logic             res_load;
   logic             res_found_in;
   logic [5:0]       res_entry_in;
   logic [2:0]       res_class_in;
   logic             res_found_ff;
   logic [5:0]       res_entry_ff;
   logic [2:0]       res_class_ff;
   logic             rsp_load;
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [5:0]       rsp_entry_ff;
   logic [2:0]       rsp_class_ff;

   assign key_req = '{rh: req_remote_addr_hi, rl: req_remote_addr_lo, rp: req_remote_port,
                      lh: req_local_addr_hi, ll: req_local_addr_lo, lp: req_local_port};
   assign accept    = req_valid && req_ready;
   assign id_idx    = id_ff[ENT_W-1:0];
   assign in_range  = ({1'b0, id_ff} < 7'(ENTRIES));
   assign old_valid = cell_valid[id_idx];

   ctlt_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   (key_req),
      .done  (hash_done),
      .bkt   (bkt)
   );

   assign chain[0] = '{tok: chain_start, hit: 1'b0, cls: 3'd0, age: '0, id: '0};

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ctlt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (ENT_W'(i)),
         .upd       (upd),
         .key       (key_ff),
         .bkt       (bkt),
         .best_prev (chain[i]),
         .best_next (chain[i+1]),
         .valid     (cell_valid[i]),
         .age       (cell_age[i]),
         .cls       (cell_cls[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_HASH;
         ST_HASH:  if (hash_done) state_in = (op_ff == OP_LOOK) ? ST_SCAN : ST_APPLY;
         ST_APPLY: state_in = ST_RESP;
         ST_SCAN:  if (chain[ENTRIES].tok) state_in = ST_RESP;
         ST_RESP:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      chain_start   = (state_ff == ST_HASH) && hash_done && (op_ff == OP_LOOK);
      rsp_load      = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);
      res_load      = 1'b0;
      res_found_in  = 1'b0;
      res_entry_in  = 6'd0;
      res_class_in  = 3'd0;
      upd           = '0;
      upd.id        = id_idx;
      upd.ins       = (op_ff == OP_INS);
      upd.old_valid = old_valid;
      upd.old_age   = cell_age[id_idx];
      upd.cls       = class_of(key_ff);
      upd.bucket    = bkt[0];
      case (state_ff)
         ST_APPLY: begin
            res_load = 1'b1;
            if (op_ff == OP_INS || op_ff == OP_REM) begin
               res_found_in = 1'b1;
               res_entry_in = id_ff;
               upd.en       = in_range;
               if (in_range && op_ff == OP_INS) begin
                  res_class_in = upd.cls;
               end else if (in_range && old_valid) begin
                  res_class_in = cell_cls[id_idx];
               end
            end
         end
         ST_SCAN: begin
            res_load = chain[ENTRIES].tok;
            if (chain[ENTRIES].hit) begin
               res_found_in = 1'b1;
               res_entry_in = 6'(chain[ENTRIES].id);
               res_class_in = chain[ENTRIES].cls;
            end
         end
         default: res_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         id_ff  <= req_entry_id;
         key_ff <= key_req;
      end
      if (res_load) begin
         res_found_ff <= res_found_in;
         res_entry_ff <= res_entry_in;
         res_class_ff <= res_class_in;
      end
      if (rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_entry_ff <= res_entry_ff;
         rsp_class_ff <= res_class_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_hit_entry = rsp_entry_ff;
   assign rsp_hit_class = rsp_class_ff;

   `CTLT_ASSERT_IMP(a_scan_end_in_scan, chain[ENTRIES].tok, state_ff == ST_SCAN)
   `CTLT_ASSERT_IMP(a_hash_done_in_hash, hash_done, state_ff == ST_HASH)
   `CTLT_ASSERT_NEXT(a_insert_sets_valid, upd.en && upd.ins, cell_valid[$past(id_idx)])
endmodule

@@ verif/connection_tuple_lookup_table_unit_checker.sv @@
// ---------------------------------------------------------------------------
// connection tuple lookup table checker
// watches the request and response channels, keeps its own copy of the
// slot table, predicts each response and compares it field by field
// ---------------------------------------------------------------------------
module connection_tuple_lookup_table_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_entry_id,
   input  logic [63:0] req_remote_addr_hi,
   input  logic [63:0] req_remote_addr_lo,
   input  logic [15:0] req_remote_port,
   input  logic [63:0] req_local_addr_hi,
   input  logic [63:0] req_local_addr_lo,
   input  logic [15:0] req_local_port,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_found,
   input  logic [5:0]  rsp_hit_entry,
   input  logic [2:0]  rsp_hit_class,
   output int          error_count,
   output int          pending_count,
   output int          lookup_hits
);
   import ctlt_pkg::*;

   typedef struct packed {
      logic       found;
      logic [5:0] entry;
      logic [2:0] cls;
   } answer_type;

   answer_type   answer_q[$];
   logic         tbl_valid [64];
   logic [2:0]   tbl_class [64];
   logic [63:0]  tbl_rh [64];
   logic [63:0]  tbl_rl [64];
   logic [63:0]  tbl_lh [64];
   logic [63:0]  tbl_ll [64];
   logic [15:0]  tbl_rp [64];
   logic [15:0]  tbl_lp [64];
   logic [9:0]   tbl_bucket [64];
   int           tbl_age [64];

   function automatic logic [9:0] bucket_calc(logic [7:0] ra, logic [15:0] rp,
                                              logic [7:0] la, logic [15:0] lp);
      logic [31:0] h;
      h = ({ra, 24'b0} ^ {rp, 16'b0}) ^ ({16'b0, la, 8'b0} ^ {16'b0, lp});
      return 10'(h % 32'd521);
   endfunction

   function automatic void drop_slot(int s);
      if (!tbl_valid[s]) return;
      for (int i = 0; i < 64; i++)
         if (tbl_valid[i] && tbl_age[i] > tbl_age[s]) tbl_age[i]--;
      tbl_valid[s] = 1'b0;
   endfunction

   function automatic answer_type predict_answer(logic [1:0] op, logic [5:0] id,
         logic [63:0] rh, logic [63:0] rl, logic [15:0] rp,
         logic [63:0] lh, logic [63:0] ll, logic [15:0] lp);
      answer_type a;
      logic [2:0] c;
      logic [9:0] b;
      int best;
      logic ok;
      a = '0;
      if (op == OP_REM) begin
         a.found = 1'b1;
         a.entry = id;
         if (tbl_valid[id]) begin
            a.cls = tbl_class[id];
            drop_slot(id);
         end
      end else if (op == OP_INS) begin
         if (rh != 0 || rl != 0) c = CL_EXACT;
         else if (lh != 0 || ll != 0) c = (lp == 0) ? CL_ADDR : CL_PA;
         else c = (lp == 0) ? CL_ANY : CL_PORT;
         drop_slot(id);
         for (int i = 0; i < 64; i++) if (tbl_valid[i]) tbl_age[i]++;
         tbl_valid[id] = 1'b1;
         tbl_class[id] = c;
         tbl_rh[id] = rh; tbl_rl[id] = rl; tbl_lh[id] = lh; tbl_ll[id] = ll;
         tbl_rp[id] = rp; tbl_lp[id] = lp;
         tbl_bucket[id] = bucket_calc(rl[7:0], rp, ll[7:0], lp);
         tbl_age[id] = 0;
         a.found = 1'b1;
         a.entry = id;
         a.cls = c;
      end else if (op == OP_LOOK) begin
         for (int k = 0; k < 5; k++) begin
            c = 3'(k);
            case (c)
               CL_EXACT: b = bucket_calc(rl[7:0], rp, ll[7:0], lp);
               CL_PA:    b = bucket_calc(8'd0, 16'd0, ll[7:0], lp);
               CL_PORT:  b = bucket_calc(8'd0, 16'd0, 8'd0, lp);
               CL_ADDR:  b = bucket_calc(8'd0, 16'd0, ll[7:0], 16'd0);
               default:  b = bucket_calc(8'd0, 16'd0, 8'd0, 16'd0);
            endcase
            best = -1;
            for (int i = 0; i < 64; i++) begin
               if (!tbl_valid[i] || tbl_class[i] != c || tbl_bucket[i] != b) continue;
               case (c)
                  CL_EXACT: ok = tbl_rp[i] == rp && tbl_lp[i] == lp && tbl_rh[i] == rh &&
                                 tbl_rl[i] == rl && tbl_lh[i] == lh && tbl_ll[i] == ll;
                  CL_PA:    ok = tbl_lp[i] == lp && tbl_lh[i] == lh && tbl_ll[i] == ll;
                  CL_PORT:  ok = tbl_lp[i] == lp;
                  CL_ADDR:  ok = tbl_lh[i] == lh && tbl_ll[i] == ll;
                  default:  ok = 1'b1;
               endcase
               if (ok && (best < 0 || tbl_age[i] < tbl_age[best])) best = i;
            end
            if (best >= 0) begin
               a.found = 1'b1;
               a.entry = 6'(best);
               a.cls = c;
               return a;
            end
         end
      end
      return a;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      pending_count = 0;
      lookup_hits = 0;
      for (int i = 0; i < 64; i++) tbl_valid[i] = 1'b0;
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_hit_entry, -1);
            end else begin
               want = answer_q.pop_front();
               if (rsp_found !== want.found) report_mismatch("found", rsp_found, want.found);
               if (rsp_hit_entry !== want.entry)
                  report_mismatch("hit_entry", rsp_hit_entry, want.entry);
               if (rsp_hit_class !== want.cls)
                  report_mismatch("hit_class", rsp_hit_class, want.cls);
            end
         end
         if (req_valid && req_ready) begin
            want = predict_answer(req_op, req_entry_id, req_remote_addr_hi,
               req_remote_addr_lo, req_remote_port, req_local_addr_hi,
               req_local_addr_lo, req_local_port);
            if (req_op == OP_LOOK && want.found) lookup_hits++;
            answer_q.push_back(want);
         end
         pending_count = answer_q.size();
      end
   end
endmodule

@@ verif/connection_tuple_lookup_table_unit_test.sv @@
// ---------------------------------------------------------------------------
// connection tuple lookup table testbench
// drives inserts, removes, lookups and the unused op with random idling on both channels;
// the checker predicts every response and counts mismatches
// ---------------------------------------------------------------------------
module connection_tuple_lookup_table_unit_test;
   import ctlt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_LOOK;
   logic [5:0]  req_entry_id = '0;
   logic [63:0] req_remote_addr_hi = '0;
   logic [63:0] req_remote_addr_lo = '0;
   logic [15:0] req_remote_port = '0;
   logic [63:0] req_local_addr_hi = '0;
   logic [63:0] req_local_addr_lo = '0;
   logic [15:0] req_local_port = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_found;
   logic [5:0]  rsp_hit_entry;
   logic [2:0]  rsp_hit_class;
   int          error_count;
   int          pending_count;
   int          lookup_hits;
   int          send_idle_pct = 14;
   int          recv_idle_pct = 53;
   int          sent_count = 0;

   // small pools so that lookups hit stored entries
   logic [63:0] addr_pool [8];
   logic [15:0] port_pool [8];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   connection_tuple_lookup_table_unit u_dut (.*);

   connection_tuple_lookup_table_unit_checker u_check (.*);

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(logic [1:0] op, logic [5:0] id, logic [63:0] rh,
                            logic [63:0] rl, logic [15:0] rp, logic [63:0] lh,
                            logic [63:0] ll, logic [15:0] lp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_op <= op; req_entry_id <= id;
      req_remote_addr_hi <= rh; req_remote_addr_lo <= rl; req_remote_port <= rp;
      req_local_addr_hi <= lh; req_local_addr_lo <= ll; req_local_port <= lp;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   function automatic logic [63:0] pick_addr();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return {$urandom, $urandom};
         default: return addr_pool[$urandom_range(7)];
      endcase
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(7))
         0: return '0;
         1: return 16'hffff;
         2: return 16'($urandom);
         default: return port_pool[$urandom_range(7)];
      endcase
   endfunction

   task automatic random_item();
      logic [1:0]  op;
      logic [63:0] rh, rl, lh, ll;
      int          pick;
      pick = $urandom_range(99);
      op = (pick < 40) ? OP_INS : (pick < 55) ? OP_REM : (pick < 98) ? OP_LOOK : OP_UNUSED;
      rh = ($urandom_range(2) == 0) ? pick_addr() : '0;
      rl = ($urandom_range(2) == 0) ? pick_addr() : '0;
      lh = ($urandom_range(1) == 0) ? pick_addr() : '0;
      ll = ($urandom_range(3) != 0) ? pick_addr() : '0;
      send_item(op, 6'($urandom_range(63)), rh, rl, pick_port(), lh, ll, pick_port());
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      for (int i = 0; i < 8; i++) begin
         addr_pool[i] = {$urandom, $urandom};
         port_pool[i] = 16'($urandom);
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: every class, replace, stale bucket, misses, invalid remove
      send_item(OP_LOOK, 6'd0, '0, '0, '0, '0, '0, '0);
      send_item(OP_REM, 6'd63, '0, '0, '0, '0, '0, '0);
      send_item(OP_INS, 6'd0, '1, '1, 16'hffff, '1, '1, 16'hffff);
      send_item(OP_INS, 6'd1, '0, '0, 16'h0, 64'h1, 64'h2, 16'h50);
      send_item(OP_INS, 6'd2, '0, '0, 16'h0, '0, '0, 16'h50);
      send_item(OP_INS, 6'd3, '0, '0, 16'h0, 64'h1, 64'h2, 16'h0);
      send_item(OP_INS, 6'd4, '0, '0, 16'h0, '0, '0, 16'h0);
      send_item(OP_INS, 6'd63, '0, '0, 16'h1234, '0, '0, 16'h0);
      send_item(OP_LOOK, 6'd0, '1, '1, 16'hffff, '1, '1, 16'hffff);
      send_item(OP_LOOK, 6'd0, 64'h5, 64'h6, 16'h7, 64'h1, 64'h2, 16'h50);
      send_item(OP_LOOK, 6'd0, 64'h5, 64'h6, 16'h7, 64'h9, 64'h9, 16'h50);
      send_item(OP_LOOK, 6'd0, 64'h5, 64'h6, 16'h7, 64'h1, 64'h2, 16'h51);
      send_item(OP_LOOK, 6'd0, 64'h5, 64'h6, 16'h7, 64'h8, 64'h8, 16'h51);
      send_item(OP_INS, 6'd2, '0, '0, 16'h0, '0, '0, 16'h50);
      send_item(OP_REM, 6'd4, '0, '0, '0, '0, '0, '0);
      send_item(OP_LOOK, 6'd0, '0, '0, '0, '0, '0, 16'h77);
      send_item(OP_UNUSED, 6'd5, '1, '1, '1, '1, '1, '1);
      send_item(OP_REM, 6'd0, '0, '0, '0, '0, '0, '0);
      send_item(OP_LOOK, 6'd0, '1, '1, 16'hffff, '1, '1, 16'hffff);
      drain_all();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 53 : 0;
         recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 14 : 0;
         for (int n = 0; n < 510; n++) begin
            random_item();
            if (n == 250) drain_all();
         end
      end
      drain_all();
      repeat (100) @(negedge clock);
      $display("covered %0d items over three idling phases, %0d lookup hits",
               sent_count, lookup_hits);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
